// ===== rtl/slab_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab allocator package
// Shared constants, status codes, memory port types and class helpers.
// ----------------------------------------------------------------------------
package slab_pkg;

  localparam int SB_COUNT    = 64;
  localparam int SB_W        = 6;
  localparam int LINK_W      = 7;
  localparam int SUPER_SHIFT = 16;
  localparam int MIN_SHIFT   = 8;
  localparam int NUM_CLASSES = 8;
  localparam int CLASS_W     = 3;
  localparam int MAX_WORDS   = 4;
  localparam int WSEL_W      = 2;
  localparam int BM_DEPTH    = SB_COUNT * MAX_WORDS;
  localparam int BM_AW       = SB_W + WSEL_W;
  localparam int POOL_W      = SB_W + SUPER_SHIFT;
  localparam int OBJ_W       = 9;
  localparam int TAG_W       = 5;
  localparam int GRANT_W     = 22;

  localparam logic [LINK_W-1:0] NIL_LINK  = 7'd64;
  localparam logic [TAG_W-1:0]  TAG_WHOLE = 5'd30;
  localparam logic [TAG_W-1:0]  TAG_FREE  = 5'd31;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FAIL     = 3'd1;
  localparam logic [2:0] ST_POOL     = 3'd2;
  localparam logic [2:0] ST_SB_DFREE = 3'd3;
  localparam logic [2:0] ST_MISALIGN = 3'd4;
  localparam logic [2:0] ST_OBJ_DFREE = 3'd5;
  localparam logic [2:0] ST_NULL     = 3'd6;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [LINK_W-1:0] nxt;
    logic [LINK_W-1:0] prv;
    logic [OBJ_W-1:0]  nfree;
    logic [WSEL_W-1:0] cur;
  } meta_t;

  localparam int META_W = $bits(meta_t);

  typedef struct packed {
    logic        action;
    logic [23:0] alloc_size;
    logic [22:0] free_offset;
    logic        free_is_null;
  } req_t;

  typedef struct packed {
    logic [SB_W-1:0] raddr;
    logic            we;
    logic [SB_W-1:0] waddr;
    meta_t           wdata;
  } meta_port_t;

  typedef struct packed {
    logic [BM_AW-1:0] raddr;
    logic             we;
    logic [BM_AW-1:0] waddr;
    logic [63:0]      wdata;
  } bm_port_t;

  function automatic logic [OBJ_W-1:0] objs_of(logic [CLASS_W-1:0] c);
    return 9'd256 >> c;
  endfunction

  function automatic logic [2:0] words_of(logic [CLASS_W-1:0] c);
    logic [OBJ_W-1:0] n;
    n = objs_of(c) + 9'd63;
    return n[8:6];
  endfunction

  function automatic logic [63:0] fill_word(logic [CLASS_W-1:0] c);
    logic [OBJ_W-1:0] n;
    n = objs_of(c);
    if (n >= 9'd64) begin
      return {64{1'b1}};
    end
    return {64{1'b1}} >> (7'd64 - n[6:0]);
  endfunction

endpackage

// ===== rtl/slab_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module slab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/slab_lowbit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab lowest set bit unit
// Isolates the lowest set bit of a bitmap word and encodes its position.
// ----------------------------------------------------------------------------
module slab_lowbit (
  input  logic [63:0] word,
  output logic [63:0] iso,
  output logic [5:0]  idx
);

  assign iso = word & (~word + 64'd1);

  always_comb begin
    idx = '0;
    for (int i = 0; i < 64; i++) begin
      idx = idx | (6'(i) & {6{iso[i]}});
    end
  end

endmodule

// ===== rtl/slab_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab sequencer
// Runs allocate and free requests step by step over the metadata and
// bitmap memories, with list heads and empty counts held in registers.
// ----------------------------------------------------------------------------
module slab_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  slab_pkg::req_t                in_req,
  input  logic                          res_ready,
  output logic                          res_valid,
  output logic [2:0]                    res_status,
  output logic [slab_pkg::GRANT_W-1:0]  res_grant,
  output slab_pkg::meta_port_t          mp,
  input  slab_pkg::meta_t               mq,
  output slab_pkg::bm_port_t            bp,
  input  logic [63:0]                   bq
);

  localparam logic [4:0] S_CLEAR   = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_DEC     = 5'd2;
  localparam logic [4:0] S_POP     = 5'd3;
  localparam logic [4:0] S_POP_RD  = 5'd4;
  localparam logic [4:0] S_RC_CLS  = 5'd5;
  localparam logic [4:0] S_RC_WALK = 5'd6;
  localparam logic [4:0] S_RC_CHK  = 5'd7;
  localparam logic [4:0] S_LR0     = 5'd8;
  localparam logic [4:0] S_LR_P    = 5'd9;
  localparam logic [4:0] S_LR_N    = 5'd10;
  localparam logic [4:0] S_LR_NW   = 5'd11;
  localparam logic [4:0] S_LR_END  = 5'd12;
  localparam logic [4:0] S_PF0     = 5'd13;
  localparam logic [4:0] S_PF1     = 5'd14;
  localparam logic [4:0] S_A_WHOLE = 5'd15;
  localparam logic [4:0] S_A_LOAD  = 5'd16;
  localparam logic [4:0] S_A_INIT  = 5'd17;
  localparam logic [4:0] S_A_FILL  = 5'd18;
  localparam logic [4:0] S_A_INIT2 = 5'd19;
  localparam logic [4:0] S_A_SCAN0 = 5'd20;
  localparam logic [4:0] S_A_SCANR = 5'd21;
  localparam logic [4:0] S_A_SCANC = 5'd22;
  localparam logic [4:0] S_A_TAKE  = 5'd23;
  localparam logic [4:0] S_A_WB    = 5'd24;
  localparam logic [4:0] S_F_META  = 5'd25;
  localparam logic [4:0] S_F_CHK   = 5'd26;
  localparam logic [4:0] S_F_BM    = 5'd27;
  localparam logic [4:0] S_F_PUSH  = 5'd28;
  localparam logic [4:0] S_DONE    = 5'd29;

  logic [4:0] state, state_next;
  logic [4:0] ret, ret_next;
  logic [4:0] sub_ret, sub_ret_next;
  slab_pkg::req_t req, req_next;
  logic [slab_pkg::CLASS_W-1:0] c, c_next;
  logic [slab_pkg::CLASS_W-1:0] lc, lc_next;
  logic [slab_pkg::SB_W-1:0] sb, sb_next;
  slab_pkg::meta_t cm, cm_next;
  logic [slab_pkg::WSEL_W-1:0] w, w_next;
  logic [3:0] rc, rc_next;
  logic [slab_pkg::LINK_W-1:0] node, node_next;
  logic [63:0] word, word_next;
  logic [63:0] iso, iso_next;
  logic [5:0] bidx, bidx_next;
  logic [2:0] status, status_next;
  logic [slab_pkg::GRANT_W-1:0] grant, grant_next;
  logic [slab_pkg::SB_W-1:0] clr, clr_next;
  logic [slab_pkg::LINK_W-1:0] fl_head, fl_head_next;
  logic [slab_pkg::LINK_W-1:0] head [slab_pkg::NUM_CLASSES];
  logic [slab_pkg::LINK_W-1:0] head_next [slab_pkg::NUM_CLASSES];
  logic [6:0] ecount [slab_pkg::NUM_CLASSES];
  logic [6:0] ecount_next [slab_pkg::NUM_CLASSES];

  logic        size_bad;
  logic [23:0] sz_m1;
  logic [7:0]  hi;
  logic [3:0]  kcls;
  logic [3:0]  sh;
  logic [15:0] in_sb;
  logic        mis;
  logic [7:0]  ordf;
  logic [15:0] ord_sh;
  logic [slab_pkg::OBJ_W-1:0] n1;
  logic [6:0]  e1;
  logic [63:0] lb_iso;
  logic [5:0]  lb_idx;

  slab_lowbit u_lowbit (
    .word (bq),
    .iso  (lb_iso),
    .idx  (lb_idx)
  );

  assign size_bad = (req.alloc_size == '0) ||
                    (req.alloc_size > 24'(1 << slab_pkg::SUPER_SHIFT));
  assign sz_m1  = req.alloc_size - 24'd1;
  assign hi     = sz_m1[slab_pkg::SUPER_SHIFT-1:slab_pkg::MIN_SHIFT];
  assign sh     = 4'(slab_pkg::MIN_SHIFT) + {1'b0, c};
  assign in_sb  = req.free_offset[slab_pkg::SUPER_SHIFT-1:0];
  assign mis    = (in_sb & ((16'd1 << sh) - 16'd1)) != '0;
  assign ordf   = 8'(in_sb >> sh);
  assign ord_sh = {8'd0, w, bidx} << sh;
  assign n1     = cm.nfree + 9'd1;
  assign e1     = ecount[c] + 7'd1;

  always_comb begin
    kcls = '0;
    for (int i = 0; i < 8; i++) begin
      if (hi[i]) begin
        kcls = 4'(i + 1);
      end
    end
  end

  assign in_ready   = (state == S_IDLE);
  assign res_valid  = (state == S_DONE);
  assign res_status = status;
  assign res_grant  = grant;

  always_comb begin
    state_next   = state;
    ret_next     = ret;
    sub_ret_next = sub_ret;
    req_next     = req;
    c_next       = c;
    lc_next      = lc;
    sb_next      = sb;
    cm_next      = cm;
    w_next       = w;
    rc_next      = rc;
    node_next    = node;
    word_next    = word;
    iso_next     = iso;
    bidx_next    = bidx;
    status_next  = status;
    grant_next   = grant;
    clr_next     = clr;
    fl_head_next = fl_head;
    head_next    = head;
    ecount_next  = ecount;
    mp = '0;
    bp = '0;
    case (state)
      S_CLEAR: begin
        mp.we          = 1'b1;
        mp.waddr       = clr;
        mp.wdata.tag   = slab_pkg::TAG_FREE;
        mp.wdata.nxt   = {1'b0, clr} + 7'd1;
        mp.wdata.prv   = slab_pkg::NIL_LINK;
        mp.wdata.nfree = '0;
        mp.wdata.cur   = '0;
        clr_next = clr + 6'd1;
        if (clr == 6'(slab_pkg::SB_COUNT - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_next   = in_req;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        grant_next = '0;
        if (req.action) begin
          if (req.free_is_null) begin
            status_next = slab_pkg::ST_NULL;
            state_next  = S_DONE;
          end else if ((req.free_offset >> slab_pkg::POOL_W) != '0) begin
            status_next = slab_pkg::ST_POOL;
            state_next  = S_DONE;
          end else begin
            sb_next    = req.free_offset[slab_pkg::POOL_W-1:slab_pkg::SUPER_SHIFT];
            mp.raddr   = req.free_offset[slab_pkg::POOL_W-1:slab_pkg::SUPER_SHIFT];
            state_next = S_F_META;
          end
        end else if (size_bad) begin
          status_next = slab_pkg::ST_FAIL;
          state_next  = S_DONE;
        end else if (kcls == 4'(slab_pkg::NUM_CLASSES)) begin
          ret_next   = S_A_WHOLE;
          state_next = S_POP;
        end else begin
          c_next = kcls[2:0];
          if (head[kcls[2:0]] >= slab_pkg::NIL_LINK) begin
            ret_next   = S_A_INIT;
            state_next = S_POP;
          end else begin
            sb_next    = head[kcls[2:0]][slab_pkg::SB_W-1:0];
            mp.raddr   = head[kcls[2:0]][slab_pkg::SB_W-1:0];
            state_next = S_A_LOAD;
          end
        end
      end
      S_POP: begin
        if (fl_head < slab_pkg::NIL_LINK) begin
          sb_next    = fl_head[slab_pkg::SB_W-1:0];
          mp.raddr   = fl_head[slab_pkg::SB_W-1:0];
          state_next = S_POP_RD;
        end else begin
          rc_next    = '0;
          state_next = S_RC_CLS;
        end
      end
      S_POP_RD: begin
        cm_next      = mq;
        cm_next.nxt  = slab_pkg::NIL_LINK;
        fl_head_next = mq.nxt;
        state_next   = ret;
      end
      S_RC_CLS: begin
        if (rc == 4'(slab_pkg::NUM_CLASSES)) begin
          status_next = slab_pkg::ST_FAIL;
          state_next  = S_DONE;
        end else if (ecount[rc[2:0]] != '0) begin
          node_next  = head[rc[2:0]];
          state_next = S_RC_WALK;
        end else begin
          rc_next = rc + 4'd1;
        end
      end
      S_RC_WALK: begin
        if (node >= slab_pkg::NIL_LINK) begin
          rc_next    = rc + 4'd1;
          state_next = S_RC_CLS;
        end else begin
          mp.raddr   = node[slab_pkg::SB_W-1:0];
          state_next = S_RC_CHK;
        end
      end
      S_RC_CHK: begin
        if (mq.nfree == slab_pkg::objs_of(rc[2:0])) begin
          sb_next              = node[slab_pkg::SB_W-1:0];
          cm_next              = mq;
          cm_next.tag          = slab_pkg::TAG_FREE;
          cm_next.nfree        = '0;
          ecount_next[rc[2:0]] = ecount[rc[2:0]] - 7'd1;
          lc_next              = rc[2:0];
          sub_ret_next         = ret;
          state_next           = S_LR0;
        end else begin
          node_next  = mq.nxt;
          state_next = S_RC_WALK;
        end
      end
      S_LR0: begin
        if (cm.prv < slab_pkg::NIL_LINK) begin
          mp.raddr   = cm.prv[slab_pkg::SB_W-1:0];
          state_next = S_LR_P;
        end else begin
          head_next[lc] = cm.nxt;
          state_next    = S_LR_N;
        end
      end
      S_LR_P: begin
        mp.we         = 1'b1;
        mp.waddr      = cm.prv[slab_pkg::SB_W-1:0];
        mp.wdata      = mq;
        mp.wdata.nxt  = cm.nxt;
        state_next    = S_LR_N;
      end
      S_LR_N: begin
        if (cm.nxt < slab_pkg::NIL_LINK) begin
          mp.raddr   = cm.nxt[slab_pkg::SB_W-1:0];
          state_next = S_LR_NW;
        end else begin
          state_next = S_LR_END;
        end
      end
      S_LR_NW: begin
        mp.we        = 1'b1;
        mp.waddr     = cm.nxt[slab_pkg::SB_W-1:0];
        mp.wdata     = mq;
        mp.wdata.prv = cm.prv;
        state_next   = S_LR_END;
      end
      S_LR_END: begin
        cm_next.prv = slab_pkg::NIL_LINK;
        cm_next.nxt = slab_pkg::NIL_LINK;
        state_next  = sub_ret;
      end
      S_PF0: begin
        cm_next.prv = slab_pkg::NIL_LINK;
        cm_next.nxt = head[c];
        if (head[c] < slab_pkg::NIL_LINK) begin
          mp.raddr   = head[c][slab_pkg::SB_W-1:0];
          state_next = S_PF1;
        end else begin
          head_next[c] = {1'b0, sb};
          state_next   = sub_ret;
        end
      end
      S_PF1: begin
        mp.we        = 1'b1;
        mp.waddr     = head[c][slab_pkg::SB_W-1:0];
        mp.wdata     = mq;
        mp.wdata.prv = {1'b0, sb};
        head_next[c] = {1'b0, sb};
        state_next   = sub_ret;
      end
      S_A_WHOLE: begin
        mp.we        = 1'b1;
        mp.waddr     = sb;
        mp.wdata     = cm;
        mp.wdata.tag = slab_pkg::TAG_WHOLE;
        grant_next   = {sb, 16'd0};
        status_next  = slab_pkg::ST_OK;
        state_next   = S_DONE;
      end
      S_A_LOAD: begin
        cm_next    = mq;
        state_next = S_A_SCAN0;
      end
      S_A_INIT: begin
        cm_next.tag   = {2'b00, c};
        cm_next.cur   = '0;
        cm_next.nfree = slab_pkg::objs_of(c);
        w_next        = '0;
        state_next    = S_A_FILL;
      end
      S_A_FILL: begin
        bp.we    = 1'b1;
        bp.waddr = {sb, w};
        bp.wdata = slab_pkg::fill_word(c);
        if (({1'b0, w} + 3'd1) == slab_pkg::words_of(c)) begin
          sub_ret_next = S_A_INIT2;
          state_next   = S_PF0;
        end else begin
          w_next = w + 2'd1;
        end
      end
      S_A_INIT2: begin
        ecount_next[c] = ecount[c] + 7'd1;
        state_next     = S_A_SCAN0;
      end
      S_A_SCAN0: begin
        w_next     = cm.cur;
        state_next = S_A_SCANR;
      end
      S_A_SCANR: begin
        if ({1'b0, w} >= slab_pkg::words_of(c)) begin
          status_next = slab_pkg::ST_FAIL;
          state_next  = S_A_WB;
        end else begin
          bp.raddr   = {sb, w};
          state_next = S_A_SCANC;
        end
      end
      S_A_SCANC: begin
        if (bq == '0) begin
          if (w == 2'(slab_pkg::MAX_WORDS - 1)) begin
            status_next = slab_pkg::ST_FAIL;
            state_next  = S_A_WB;
          end else begin
            w_next     = w + 2'd1;
            state_next = S_A_SCANR;
          end
        end else if (cm.nfree == '0) begin
          status_next = slab_pkg::ST_FAIL;
          state_next  = S_A_WB;
        end else begin
          word_next  = bq;
          iso_next   = lb_iso;
          bidx_next  = lb_idx;
          state_next = S_A_TAKE;
        end
      end
      S_A_TAKE: begin
        if (cm.nfree == slab_pkg::objs_of(c)) begin
          ecount_next[c] = ecount[c] - 7'd1;
        end
        cm_next.cur   = w;
        cm_next.nfree = cm.nfree - 9'd1;
        bp.we         = 1'b1;
        bp.waddr      = {sb, w};
        bp.wdata      = word & ~iso;
        grant_next    = {sb, ord_sh};
        status_next   = slab_pkg::ST_OK;
        if (cm.nfree == 9'd1) begin
          lc_next      = c;
          sub_ret_next = S_A_WB;
          state_next   = S_LR0;
        end else begin
          state_next = S_A_WB;
        end
      end
      S_A_WB: begin
        mp.we      = 1'b1;
        mp.waddr   = sb;
        mp.wdata   = cm;
        state_next = S_DONE;
      end
      S_F_META: begin
        cm_next    = mq;
        c_next     = mq.tag[slab_pkg::CLASS_W-1:0];
        state_next = S_F_CHK;
      end
      S_F_CHK: begin
        if (cm.tag == slab_pkg::TAG_FREE) begin
          status_next = slab_pkg::ST_SB_DFREE;
          state_next  = S_DONE;
        end else if (cm.tag >= 5'(slab_pkg::NUM_CLASSES)) begin
          if (in_sb != '0) begin
            status_next = slab_pkg::ST_MISALIGN;
          end else begin
            mp.we        = 1'b1;
            mp.waddr     = sb;
            mp.wdata     = cm;
            mp.wdata.tag = slab_pkg::TAG_FREE;
            mp.wdata.nxt = fl_head;
            fl_head_next = {1'b0, sb};
            status_next  = slab_pkg::ST_OK;
          end
          state_next = S_DONE;
        end else if (mis) begin
          status_next = slab_pkg::ST_MISALIGN;
          state_next  = S_DONE;
        end else begin
          w_next     = ordf[7:6];
          bidx_next  = ordf[5:0];
          bp.raddr   = {sb, ordf[7:6]};
          state_next = S_F_BM;
        end
      end
      S_F_BM: begin
        if (bq[bidx]) begin
          status_next = slab_pkg::ST_OBJ_DFREE;
          state_next  = S_DONE;
        end else begin
          bp.we         = 1'b1;
          bp.waddr      = {sb, w};
          bp.wdata      = bq | (64'd1 << bidx);
          status_next   = slab_pkg::ST_OK;
          cm_next.nfree = n1;
          if (w < cm.cur) begin
            cm_next.cur = w;
          end
          if (n1 == slab_pkg::objs_of(c)) begin
            if (e1 > 7'd1) begin
              cm_next.tag   = slab_pkg::TAG_FREE;
              cm_next.nfree = '0;
              lc_next       = c;
              sub_ret_next  = S_F_PUSH;
              state_next    = S_LR0;
            end else begin
              ecount_next[c] = e1;
              state_next     = S_A_WB;
            end
          end else if (n1 == 9'd1) begin
            sub_ret_next = S_A_WB;
            state_next   = S_PF0;
          end else begin
            state_next = S_A_WB;
          end
        end
      end
      S_F_PUSH: begin
        cm_next.nxt  = fl_head;
        fl_head_next = {1'b0, sb};
        state_next   = S_A_WB;
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr     <= '0;
      fl_head <= '0;
      for (int i = 0; i < slab_pkg::NUM_CLASSES; i++) begin
        head[i]   <= slab_pkg::NIL_LINK;
        ecount[i] <= '0;
      end
    end else begin
      state   <= state_next;
      clr     <= clr_next;
      fl_head <= fl_head_next;
      head    <= head_next;
      ecount  <= ecount_next;
    end
  end

  always_ff @(posedge clk) begin
    ret     <= ret_next;
    sub_ret <= sub_ret_next;
    req     <= req_next;
    c       <= c_next;
    lc      <= lc_next;
    sb      <= sb_next;
    cm      <= cm_next;
    w       <= w_next;
    rc      <= rc_next;
    node    <= node_next;
    word    <= word_next;
    iso     <= iso_next;
    bidx    <= bidx_next;
    status  <= status_next;
    grant   <= grant_next;
  end

endmodule

// ===== rtl/slab_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab allocator
// Power-of-two class allocator over a pool of superblocks.
//
//   Port group  Direction  Contents
//   s_*         in         one request word: allocate or free
//   m_*         out        one result word per request: status and offset
//
// The sequencer makes one metadata or bitmap memory access per cycle, and
// each list link update, bitmap word scan and reclaim list step is one read.
// An error found at decode goes straight to the result, and an allocate that
// must reclaim an empty superblock walks the class lists.
// After reset a clearing pass over every superblock initializes the metadata
// memory; no request is accepted meanwhile. A finished result waits in the
// output register while the next request is accepted.
// ----------------------------------------------------------------------------
module slab_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // alloc_size[23:0], free_offset[46:24], free_is_null[47]
  input  logic [0:0]  s_tuser,  // action[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // granted_offset[21:0], zero[23:22]
  output logic [2:0]  m_tuser   // status[2:0]
);

  slab_pkg::req_t       in_req;
  slab_pkg::meta_port_t mp;
  slab_pkg::meta_t      mq;
  slab_pkg::bm_port_t   bp;
  logic [slab_pkg::META_W-1:0] meta_rdata;
  logic [63:0] bq;
  logic        res_ready;
  logic        res_valid;
  logic [2:0]  res_status;
  logic [slab_pkg::GRANT_W-1:0] res_grant;

  assign in_req.action       = s_tuser[0];
  assign in_req.alloc_size   = s_tdata[23:0];
  assign in_req.free_offset  = s_tdata[46:24];
  assign in_req.free_is_null = s_tdata[47];
  assign mq = slab_pkg::meta_t'(meta_rdata);

  assign res_ready = !m_tvalid || m_tready;

  slab_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_req     (in_req),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res_status (res_status),
    .res_grant  (res_grant),
    .mp         (mp),
    .mq         (mq),
    .bp         (bp),
    .bq         (bq)
  );

  slab_ram #(
    .WIDTH (slab_pkg::META_W),
    .DEPTH (slab_pkg::SB_COUNT)
  ) u_meta_ram (
    .clk   (clk),
    .we    (mp.we),
    .waddr (mp.waddr),
    .wdata (mp.wdata),
    .raddr (mp.raddr),
    .rdata (meta_rdata)
  );

  slab_ram #(
    .WIDTH (64),
    .DEPTH (slab_pkg::BM_DEPTH)
  ) u_bitmap_ram (
    .clk   (clk),
    .we    (bp.we),
    .waddr (bp.waddr),
    .wdata (bp.wdata),
    .raddr (bp.raddr),
    .rdata (bq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {2'b00, res_grant};
      m_tuser <= res_status;
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab allocator testbench
// Drives allocate and free words from a directed table and then at random,
// keeps its own model of the superblock pool, and compares each result word
// with the oldest predicted one.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NBLK = 64;
  localparam int NIL = 64;
  localparam int RANDOM_WORDS = 950;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic        action;
    logic [23:0] size;
    logic [22:0] offset;
    logic        is_null;
    logic        known;
    logic [2:0]  status;
    logic [21:0] grant;
  } row_t;

  typedef struct {
    logic [2:0]  status;
    logic [21:0] grant;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [2:0]  m_tuser;

  int     errors = 0;
  int     cycles = 0;
  logic   calm = 1'b0;
  outcome_t pending[$];
  logic [21:0] live[$];

  int          tag[NBLK];
  int          nxt[NBLK];
  int          prv[NBLK];
  int          nfree[NBLK];
  int          cursor[NBLK];
  logic [63:0] bits[NBLK][4];
  int          head[8];
  int          empties[8];
  int          free_head;

  slab_allocator dut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int objs(int c);
    return 256 >> c;
  endfunction

  function automatic int nwords(int c);
    return (objs(c) + 63) / 64;
  endfunction

  function automatic void pool_reset();
    for (int i = 0; i < NBLK; i++) begin
      tag[i] = 31; nxt[i] = i + 1; prv[i] = NIL; nfree[i] = 0; cursor[i] = 0;
      for (int w = 0; w < 4; w++) bits[i][w] = '0;
    end
    for (int c = 0; c < 8; c++) begin
      head[c] = NIL; empties[c] = 0;
    end
    free_head = 0;
  endfunction

  function automatic void push_front(int c, int b);
    prv[b] = NIL; nxt[b] = head[c];
    if (head[c] < NBLK) prv[head[c]] = b;
    head[c] = b;
  endfunction

  function automatic void unlink(int c, int b);
    int p, n;
    p = prv[b]; n = nxt[b];
    if (p < NBLK) nxt[p] = n; else head[c] = n;
    if (n < NBLK) prv[n] = p;
    prv[b] = NIL; nxt[b] = NIL;
  endfunction

  function automatic void retire(int c, int b);
    unlink(c, b);
    empties[c] = (empties[c] - 1) & 8'h7f;
    tag[b] = 31; nfree[b] = 0;
    for (int w = 0; w < nwords(c); w++) bits[b][w] = '0;
  endfunction

  function automatic int take_block();
    int b, steps;
    b = free_head;
    if (b < NBLK) begin
      free_head = nxt[b]; nxt[b] = NIL;
      return b;
    end
    for (int c = 0; c < 8; c++) begin
      if (empties[c] == 0) continue;
      b = head[c];
      for (steps = 0; b < NBLK && steps < NBLK; steps++) begin
        if (nfree[b] == objs(c)) begin
          retire(c, b);
          return b;
        end
        b = nxt[b];
      end
    end
    return NIL;
  endfunction

  function automatic outcome_t pool_alloc(int size);
    outcome_t r;
    int s, b, c, w, bitn, cnt;
    r = '{slab_pkg::ST_FAIL, '0};
    if (size == 0 || size > 65536) return r;
    s = 8;
    while ((1 << s) < size) s++;
    if (s >= 16) begin
      b = take_block();
      if (b >= NBLK) return r;
      tag[b] = 30;
      return '{slab_pkg::ST_OK, 22'(b << 16)};
    end
    c = s - 8; cnt = objs(c);
    b = head[c];
    if (b >= NBLK) begin
      b = take_block();
      if (b >= NBLK) return r;
      tag[b] = c; cursor[b] = 0; nfree[b] = cnt;
      for (w = 0; w < nwords(c); w++)
        bits[b][w] = (cnt - w * 64 >= 64) ? '1 : ((64'd1 << cnt) - 1);
      push_front(c, b);
      empties[c] = (empties[c] + 1) & 8'h7f;
    end
    w = cursor[b];
    while (w < nwords(c) && bits[b][w] == 0) w++;
    if (w >= nwords(c) || nfree[b] == 0) return r;
    if (nfree[b] == cnt) empties[c] = (empties[c] - 1) & 8'h7f;
    cursor[b] = w;
    bitn = 0;
    while (bitn < 63 && !bits[b][w][bitn]) bitn++;
    bits[b][w][bitn] = 1'b0;
    nfree[b]--;
    if (nfree[b] == 0) unlink(c, b);
    return '{slab_pkg::ST_OK, 22'((b << 16) + ((w * 64 + bitn) << s))};
  endfunction

  function automatic logic [2:0] pool_free(int off);
    int b, c, ord, w;
    if (off >= NBLK * 65536) return slab_pkg::ST_POOL;
    b = off >> 16;
    if (tag[b] == 31) return slab_pkg::ST_SB_DFREE;
    if (tag[b] >= 8) begin
      if ((off & 16'hffff) != 0) return slab_pkg::ST_MISALIGN;
      tag[b] = 31; nxt[b] = free_head; free_head = b;
      return slab_pkg::ST_OK;
    end
    c = tag[b];
    if ((off & ((1 << (8 + c)) - 1)) != 0) return slab_pkg::ST_MISALIGN;
    ord = (off & 16'hffff) >> (8 + c);
    w = ord / 64;
    if (w >= 4) return slab_pkg::ST_MISALIGN;
    if (bits[b][w][ord % 64]) return slab_pkg::ST_OBJ_DFREE;
    bits[b][w][ord % 64] = 1'b1;
    if (w < cursor[b]) cursor[b] = w;
    nfree[b]++;
    if (nfree[b] == objs(c)) begin
      empties[c] = (empties[c] + 1) & 8'h7f;
      if (empties[c] > 1) begin
        retire(c, b);
        nxt[b] = free_head; free_head = b;
      end
    end else if (nfree[b] == 1) begin
      push_front(c, b);
    end
    return slab_pkg::ST_OK;
  endfunction

  function automatic outcome_t predict_result(row_t r);
    if (!r.action) return pool_alloc(int'(r.size));
    if (r.is_null) return '{slab_pkg::ST_NULL, '0};
    return '{pool_free(int'(r.offset)), '0};
  endfunction

  task automatic send_word(row_t r);
    outcome_t o;
    o = predict_result(r);
    if (r.known) begin
      if (o.status !== r.status) begin
        $error("table status expected %0d actual %0d", r.status, o.status);
        errors++;
      end
      if (o.grant !== r.grant) begin
        $error("table granted_offset expected %0h actual %0h", r.grant, o.grant);
        errors++;
      end
      o = '{r.status, r.grant};
    end
    if (!r.action && o.status == slab_pkg::ST_OK) live.push_back(o.grant);
    pending.push_back(o);
    while (!calm && $urandom_range(99) < 12) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= r.action;
    s_tdata <= {r.is_null, r.offset, r.size};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    outcome_t o;
    if (!rst) m_tready <= calm || ($urandom_range(99) >= 12);
    if (m_tvalid && m_tready) begin
      if (pending.size() == 0) begin
        $error("unexpected result word status %0d", m_tuser);
        errors++;
      end else begin
        o = pending.pop_front();
        if (m_tuser !== o.status) begin
          $error("status expected %0d actual %0d", o.status, m_tuser);
          errors++;
        end
        if (m_tdata !== {2'b00, o.grant}) begin
          $error("granted_offset expected %0h actual %0h", o.grant, m_tdata);
          errors++;
        end
      end
    end
  end

  function automatic row_t mk(logic a, int sz, int off, logic nul);
    return '{a, 24'(sz), 23'(off), nul, 1'b0, '0, '0};
  endfunction

  function automatic row_t mkk(logic a, int sz, int off, logic nul, logic [2:0] st, int g);
    return '{a, 24'(sz), 23'(off), nul, 1'b1, st, 22'(g)};
  endfunction

  initial begin
    row_t table_rows[$];
    row_t r;
    int k, sel;
    pool_reset();
    table_rows = '{
      mkk(1, 0, 0, 0, slab_pkg::ST_SB_DFREE, 0),
      mkk(1, 0, 23'h7fffff, 1, slab_pkg::ST_NULL, 0),
      mkk(1, 24'hffffff, 23'h7fffff, 0, slab_pkg::ST_POOL, 0),
      mkk(0, 0, 0, 0, slab_pkg::ST_FAIL, 0),
      mkk(0, 24'hffffff, 23'h7fffff, 1, slab_pkg::ST_FAIL, 0),
      mkk(0, 65537, 0, 0, slab_pkg::ST_FAIL, 0),
      mkk(0, 1, 0, 0, slab_pkg::ST_OK, 0),
      mkk(0, 256, 0, 0, slab_pkg::ST_OK, 256),
      mkk(0, 257, 0, 0, slab_pkg::ST_OK, 65536),
      mk(0, 32768, 0, 0),
      mk(0, 32769, 0, 0),
      mk(0, 65536, 0, 0),
      mk(0, 1000, 0, 0),
      mk(0, 5000, 0, 0),
      mk(0, 20000, 0, 0),
      mkk(1, 0, 1, 0, slab_pkg::ST_MISALIGN, 0),
      mkk(1, 0, 256, 0, slab_pkg::ST_OK, 0),
      mkk(1, 0, 256, 0, slab_pkg::ST_OBJ_DFREE, 0),
      mkk(1, 0, 65536, 0, slab_pkg::ST_OK, 0),
      mk(1, 0, 196608, 0),
      mk(1, 0, 196609, 0),
      mk(1, 0, 0, 0)
    };
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (table_rows[i]) send_word(table_rows[i]);
    // Exhaust the pool with whole superblocks, then release them.
    for (k = 0; k < 70; k++) send_word(mk(0, 65536, $urandom, 0));
    s_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    while (live.size() != 0) begin
      sel = $urandom_range(live.size() - 1);
      send_word(mk(1, $urandom, live[sel], 0));
      live.delete(sel);
    end
    for (k = 0; k < RANDOM_WORDS; k++) begin
      calm = (k >= 300 && k < 450);
      if (k == 600) begin
        s_tvalid <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
      end
      sel = $urandom_range(99);
      if (sel < 45 || live.size() == 0) begin
        case ($urandom_range(3))
          0: r = mk(0, $urandom_range(1, 256), $urandom, 1'($urandom));
          1: r = mk(0, $urandom_range(1, 32768), $urandom, 1'($urandom));
          2: r = mk(0, $urandom_range(32769, 65536), $urandom, 1'($urandom));
          default: r = mk(0, $urandom, $urandom, 1'($urandom));
        endcase
        if (live.size() > 200) r.action = 1'b1;
        if (r.action) r = mk(1, $urandom, live.size() ? live[0] : 0, 0);
        if (r.action && live.size()) live.delete(0);
      end else if (sel < 88) begin
        sel = $urandom_range(live.size() - 1);
        r = mk(1, $urandom, live[sel], 0);
        live.delete(sel);
      end else begin
        r = mk(1, $urandom, $urandom, $urandom_range(3) == 0);
      end
      send_word(r);
    end
    calm = 1'b0;
    s_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/slab_pkg.sv
rtl/slab_ram.sv
rtl/slab_lowbit.sv
rtl/slab_ctrl.sv
rtl/slab_allocator.sv
bench/testbench.sv
